// ----- rtl/core/idc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idc_pkg
// Shared widths, codes and stage payload types of the intra DC predictor.
// ----------------------------------------------------------------------------
package idc_pkg;

  localparam int unsigned BLK_W    = 3;
  localparam int unsigned DC_W     = 13;
  localparam int unsigned SCALE_W  = 7;
  localparam int unsigned AIC_W    = 2;
  localparam int unsigned SUM_W    = 14;
  localparam int unsigned VER_W    = 3;
  localparam int unsigned NUM_W    = 14;  // rounded numerator, max 8191 + 63
  localparam int unsigned RECIP_SHIFT = 21;
  localparam int unsigned RECIP_W  = 22;  // ceil(2^21 / d) for d in 1..127
  localparam int unsigned PROD_W   = NUM_W + RECIP_W;
  localparam int unsigned SCALE_DEPTH = 1 << SCALE_W;

  localparam int unsigned IN_DATA_W  = 88;
  localparam int unsigned OUT_DATA_W = 16;

  // codec_version codes
  localparam logic [VER_W-1:0] CODEC_V3    = 3'd2;
  localparam logic [VER_W-1:0] CODEC_WMV1  = 3'd3;
  localparam logic [VER_W-1:0] CODEC_RESET = CODEC_V3;

  // luma block numbers with their own inter-intra rule
  localparam logic [BLK_W-1:0] BLK_Y0 = 3'd0;
  localparam logic [BLK_W-1:0] BLK_Y1 = 3'd1;
  localparam logic [BLK_W-1:0] BLK_Y2 = 3'd2;
  localparam logic [BLK_W-1:0] BLK_Y3 = 3'd3;

  // advanced intra direction codes
  localparam logic [AIC_W-1:0] AIC_LEFT     = 2'd0;
  localparam logic [AIC_W-1:0] AIC_Y0_ABOVE = 2'd1;
  localparam logic [AIC_W-1:0] AIC_Y0_LEFT  = 2'd2;
  localparam logic [AIC_W-1:0] AIC_ABOVE    = 2'd3;

  localparam logic DIR_LEFT  = 1'b0;
  localparam logic DIR_ABOVE = 1'b1;

  localparam logic [NUM_W-1:0] EDGE_DC = 14'd1024;

  typedef struct packed {
    logic [BLK_W-1:0]   block_num;
    logic [DC_W-1:0]    dc_left;
    logic [DC_W-1:0]    dc_above_left;
    logic [DC_W-1:0]    dc_above;
    logic [SCALE_W-1:0] dc_scale;
    logic               first_row;
    logic               inter_intra;
    logic [AIC_W-1:0]   aic_dir;
    logic [SUM_W-1:0]   left_pixel_sum;
    logic [SUM_W-1:0]   top_pixel_sum;
    logic               at_left_edge;
    logic               at_top_edge;
  } idc_item_t;

  typedef struct packed {
    logic fixed;      // direction decided without the gradient test
    logic fixed_dir;
    logic strict;     // gradient test uses < instead of <=
  } idc_ctl_t;

  typedef struct packed {
    idc_ctl_t           ctl;
    logic [NUM_W-1:0]   num_a;
    logic [NUM_W-1:0]   num_b;
    logic [NUM_W-1:0]   num_c;
    logic [RECIP_W-1:0] recip;
  } idc_prep_t;

  typedef struct packed {
    idc_ctl_t        ctl;
    logic [DC_W-1:0] q_a;
    logic [DC_W-1:0] q_b;
    logic [DC_W-1:0] q_c;
  } idc_quot_t;

  typedef struct packed {
    logic [DC_W-1:0] prediction;
    logic            direction;
  } idc_res_t;

endpackage
`default_nettype wire

// ----- rtl/core/idc_prep.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idc_prep
// Stage 1: mode decode, rounded numerators and reciprocal lookup.
// ----------------------------------------------------------------------------
module idc_prep (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [idc_pkg::VER_W-1:0] codec_version,
  input  wire logic                      valid_i,
  output      logic                      ready_o,
  input  wire idc_pkg::idc_item_t        item_i,
  output      logic                      valid_o,
  input  wire logic                      ready_i,
  output      idc_pkg::idc_prep_t        data_o
);
  import idc_pkg::*;

  logic [RECIP_W-1:0] recip_tbl [SCALE_DEPTH];

  // reciprocal table, ceil(2^21 / d); a zero scale acts as one
  for (genvar g = 0; g < SCALE_DEPTH; g++) begin : g_recip
    localparam int unsigned DIVISOR = (g == 0) ? 1 : g;
    localparam int unsigned RV = ((32'd1 << RECIP_SHIFT) + DIVISOR - 1) / DIVISOR;
    assign recip_tbl[g] = RV[RECIP_W-1:0];
  end

  logic               valid_r;
  idc_prep_t          data_r;
  idc_prep_t          data_nxt;
  logic [SCALE_W-1:0] scale;
  logic [SCALE_W-2:0] half;
  logic               newer;
  logic               repl;
  logic               fixed_blk;
  logic               pix;
  logic [DC_W-1:0]    b_v;
  logic [DC_W-1:0]    c_v;
  logic [SUM_W:0]     lsum_rnd;
  logic [SUM_W:0]     tsum_rnd;
  logic [NUM_W-1:0]   edge_num;
  logic [NUM_W-1:0]   lnum;
  logic [NUM_W-1:0]   tnum;
  logic               aic_above;

  always_comb begin
    scale = (item_i.dc_scale == '0) ? SCALE_W'(1) : item_i.dc_scale;
    half  = scale[SCALE_W-1:1];
    newer = (codec_version >= CODEC_WMV1);
    repl  = item_i.first_row && !item_i.block_num[1] && !newer;
    b_v   = repl ? EDGE_DC[DC_W-1:0] : item_i.dc_above_left;
    c_v   = repl ? EDGE_DC[DC_W-1:0] : item_i.dc_above;

    fixed_blk = (item_i.block_num == BLK_Y1) || (item_i.block_num == BLK_Y2) ||
                (item_i.block_num == BLK_Y3);
    pix       = newer && item_i.inter_intra && !fixed_blk;

    // divide by 8*scale as floor((sum + 4*scale) / 8) / scale
    lsum_rnd = {1'b0, item_i.left_pixel_sum} + {6'd0, scale, 2'b00};
    tsum_rnd = {1'b0, item_i.top_pixel_sum} + {6'd0, scale, 2'b00};
    edge_num = EDGE_DC + {8'd0, half};
    lnum = item_i.at_left_edge ? edge_num : {2'b00, lsum_rnd[SUM_W:3]};
    tnum = item_i.at_top_edge  ? edge_num : {2'b00, tsum_rnd[SUM_W:3]};

    unique case (item_i.aic_dir)
      AIC_LEFT:     aic_above = DIR_LEFT;
      AIC_Y0_ABOVE: aic_above = (item_i.block_num == BLK_Y0);
      AIC_Y0_LEFT:  aic_above = (item_i.block_num != BLK_Y0);
      AIC_ABOVE:    aic_above = DIR_ABOVE;
      default:      aic_above = DIR_LEFT;
    endcase

    data_nxt.ctl.strict = newer;
    data_nxt.ctl.fixed  = newer && item_i.inter_intra && (item_i.block_num != BLK_Y3);
    priority if (pix) begin
      data_nxt.ctl.fixed_dir = aic_above;
    end else if (item_i.block_num == BLK_Y2) begin
      data_nxt.ctl.fixed_dir = DIR_ABOVE;
    end else begin
      data_nxt.ctl.fixed_dir = DIR_LEFT;
    end

    data_nxt.num_a = pix ? lnum : ({1'b0, item_i.dc_left} + {8'd0, half});
    data_nxt.num_b = {1'b0, b_v} + {8'd0, half};
    data_nxt.num_c = pix ? tnum : ({1'b0, c_v} + {8'd0, half});
    data_nxt.recip = recip_tbl[scale];
  end

  assign ready_o = !valid_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      data_r <= data_nxt;
    end
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;

endmodule
`default_nettype wire

// ----- rtl/core/idc_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idc_div
// Stage 2: three reciprocal multipliers give the quotients by the DC scale.
// ----------------------------------------------------------------------------
module idc_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               valid_i,
  output      logic               ready_o,
  input  wire idc_pkg::idc_prep_t data_i,
  output      logic               valid_o,
  input  wire logic               ready_i,
  output      idc_pkg::idc_quot_t data_o
);
  import idc_pkg::*;

  logic              valid_r;
  idc_quot_t         data_r;
  idc_quot_t         data_nxt;
  logic [PROD_W-1:0] prod_a;
  logic [PROD_W-1:0] prod_b;
  logic [PROD_W-1:0] prod_c;

  // exact for numerators below 2^14 and divisors below 2^7
  always_comb begin
    prod_a = PROD_W'(data_i.num_a) * PROD_W'(data_i.recip);
    prod_b = PROD_W'(data_i.num_b) * PROD_W'(data_i.recip);
    prod_c = PROD_W'(data_i.num_c) * PROD_W'(data_i.recip);
    data_nxt.ctl = data_i.ctl;
    data_nxt.q_a = prod_a[RECIP_SHIFT +: DC_W];
    data_nxt.q_b = prod_b[RECIP_SHIFT +: DC_W];
    data_nxt.q_c = prod_c[RECIP_SHIFT +: DC_W];
  end

  assign ready_o = !valid_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      data_r <= data_nxt;
    end
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;

endmodule
`default_nettype wire

// ----- rtl/core/idc_sel.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idc_sel
// Stage 3: gradient compare and selection into the output register.
// ----------------------------------------------------------------------------
module idc_sel (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               valid_i,
  output      logic               ready_o,
  input  wire idc_pkg::idc_quot_t data_i,
  output      logic               valid_o,
  input  wire logic               ready_i,
  output      idc_pkg::idc_res_t  data_o
);
  import idc_pkg::*;

  logic            valid_r;
  idc_res_t        data_r;
  idc_res_t        data_nxt;
  logic [DC_W-1:0] dab;
  logic [DC_W-1:0] dbc;
  logic            above;

  always_comb begin
    dab = (data_i.q_a > data_i.q_b) ? data_i.q_a - data_i.q_b : data_i.q_b - data_i.q_a;
    dbc = (data_i.q_b > data_i.q_c) ? data_i.q_b - data_i.q_c : data_i.q_c - data_i.q_b;
    priority if (data_i.ctl.fixed) begin
      above = data_i.ctl.fixed_dir;
    end else if (data_i.ctl.strict) begin
      above = (dab < dbc);
    end else begin
      above = (dab <= dbc);
    end
    data_nxt.direction  = above ? DIR_ABOVE : DIR_LEFT;
    data_nxt.prediction = above ? data_i.q_c : data_i.q_a;
  end

  assign ready_o = !valid_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      data_r <= data_nxt;
    end
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;

endmodule
`default_nettype wire

// ----- rtl/core/intra_dc_gradient_predictor.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// intra_dc_gradient_predictor
// Intra DC prediction for one 8x8 block per transaction.
// ----------------------------------------------------------------------------
// Takes one block per cycle unless a stalled output has filled every stage.
// Three register stages: numerator rounding with a 128-entry reciprocal
// table, three 14x22 reciprocal multipliers that divide by the DC scale,
// then the gradient compare into the output register. Every stage holds
// a valid bit and fills bubbles, so a stalled output only holds the
// stages behind it once they are full. codec_version is written through
// cfg_wr_en / cfg_wr_data and is read by the first stage, so write it only
// while the pipeline is empty.
module intra_dc_gradient_predictor (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_wr_en,
  input  wire logic [idc_pkg::VER_W-1:0]        cfg_wr_data,
  input  wire logic                             in_tvalid,
  output      logic                             in_tready,
  // block_num[2:0], dc_left[15:3], dc_above_left[28:16], dc_above[41:29],
  // dc_scale[48:42], first_row[49], inter_intra[50], aic_dir[52:51],
  // left_pixel_sum[66:53], top_pixel_sum[80:67], at_left_edge[81],
  // at_top_edge[82], zero[87:83]
  input  wire logic [idc_pkg::IN_DATA_W-1:0]    in_tdata,
  output      logic                             out_tvalid,
  input  wire logic                             out_tready,
  // prediction[12:0], direction[13], zero[15:14]
  output      logic [idc_pkg::OUT_DATA_W-1:0]   out_tdata
);
  import idc_pkg::*;

  logic [VER_W-1:0] codec_version_r;
  idc_item_t        item;
  logic             prep_valid;
  logic             prep_ready;
  idc_prep_t        prep_data;
  logic             quot_valid;
  logic             quot_ready;
  idc_quot_t        quot_data;
  idc_res_t         res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codec_version_r <= CODEC_RESET;
    end else if (cfg_wr_en) begin
      codec_version_r <= cfg_wr_data;
    end
  end

  assign item.block_num      = in_tdata[2:0];
  assign item.dc_left        = in_tdata[15:3];
  assign item.dc_above_left  = in_tdata[28:16];
  assign item.dc_above       = in_tdata[41:29];
  assign item.dc_scale       = in_tdata[48:42];
  assign item.first_row      = in_tdata[49];
  assign item.inter_intra    = in_tdata[50];
  assign item.aic_dir        = in_tdata[52:51];
  assign item.left_pixel_sum = in_tdata[66:53];
  assign item.top_pixel_sum  = in_tdata[80:67];
  assign item.at_left_edge   = in_tdata[81];
  assign item.at_top_edge    = in_tdata[82];

  idc_prep u_prep (
    .clk           (clk),
    .rst_n         (rst_n),
    .codec_version (codec_version_r),
    .valid_i       (in_tvalid),
    .ready_o       (in_tready),
    .item_i        (item),
    .valid_o       (prep_valid),
    .ready_i       (prep_ready),
    .data_o        (prep_data)
  );

  idc_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (prep_valid),
    .ready_o (prep_ready),
    .data_i  (prep_data),
    .valid_o (quot_valid),
    .ready_i (quot_ready),
    .data_o  (quot_data)
  );

  idc_sel u_sel (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (quot_valid),
    .ready_o (quot_ready),
    .data_i  (quot_data),
    .valid_o (out_tvalid),
    .ready_i (out_tready),
    .data_o  (res)
  );

  assign out_tdata = {2'b00, res.direction, res.prediction};

endmodule
`default_nettype wire

// ----- rtl/core/idc_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idc_checker
// Port-level checks of the intra DC predictor, bound to the top level.
// ----------------------------------------------------------------------------
module idc_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_tvalid,
  input wire logic                           in_tready,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [idc_pkg::OUT_DATA_W-1:0] out_tdata
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output transaction changed or dropped");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // input backpressure only when every stage is full and the output stalls
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled while the pipeline can advance");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[15:14] == 2'b00)
    else $error("output padding bits not zero");

endmodule

bind intra_dc_gradient_predictor idc_checker u_idc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

// ----- sim/idc_prediction_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idc_prediction_checker
// Watches the predictor's channels, predicts each DC result and compares.
// ----------------------------------------------------------------------------
// Every accepted input transaction is predicted with the codec version seen
// on the configuration port and queued. Every accepted output transaction is
// compared field by field with the oldest queued prediction.
module idc_prediction_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [idc_pkg::VER_W-1:0]       cfg_wr_data,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [idc_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [idc_pkg::OUT_DATA_W-1:0]  out_tdata,
  output int                              mismatch_count,
  output int                              pending_count
);
  import idc_pkg::*;

  localparam int MAX_REPORTS = 10;

  idc_res_t         expected_dc_q[$];
  logic [VER_W-1:0] codec_ver;

  initial begin
    mismatch_count = 0;
    pending_count  = 0;
  end

  function automatic int unsigned div_round(int unsigned num, int unsigned den);
    return (num + den / 2) / den;
  endfunction

  function automatic int abs_gap(int x, int y);
    return (x > y) ? x - y : y - x;
  endfunction

  function automatic idc_res_t predict_dc(idc_item_t blk, logic [VER_W-1:0] ver);
    idc_res_t    res;
    int unsigned sc;
    int unsigned q_a;
    int unsigned q_b;
    int unsigned q_c;
    logic        newer;
    logic        dir;
    newer = (ver >= CODEC_WMV1);
    sc    = (blk.dc_scale == '0) ? 1 : 32'(blk.dc_scale);
    q_a   = 32'(blk.dc_left);
    q_b   = 32'(blk.dc_above_left);
    q_c   = 32'(blk.dc_above);
    // older variants see a flat 1024 above the first slice line
    if (blk.first_row && !blk.block_num[1] && !newer) begin
      q_b = 32'(EDGE_DC);
      q_c = 32'(EDGE_DC);
    end
    q_a = div_round(q_a, sc);
    q_b = div_round(q_b, sc);
    q_c = div_round(q_c, sc);
    if (newer && blk.inter_intra) begin
      case (blk.block_num)
        BLK_Y1: dir = DIR_LEFT;
        BLK_Y2: dir = DIR_ABOVE;
        BLK_Y3: dir = (abs_gap(q_a, q_b) < abs_gap(q_b, q_c)) ? DIR_ABOVE : DIR_LEFT;
        default: begin
          q_a = blk.at_left_edge ? div_round(32'(EDGE_DC), sc)
                                 : div_round(32'(blk.left_pixel_sum), sc * 8);
          q_c = blk.at_top_edge  ? div_round(32'(EDGE_DC), sc)
                                 : div_round(32'(blk.top_pixel_sum), sc * 8);
          case (blk.aic_dir)
            AIC_LEFT:     dir = DIR_LEFT;
            AIC_Y0_ABOVE: dir = (blk.block_num == BLK_Y0) ? DIR_ABOVE : DIR_LEFT;
            AIC_Y0_LEFT:  dir = (blk.block_num == BLK_Y0) ? DIR_LEFT : DIR_ABOVE;
            default:      dir = DIR_ABOVE;
          endcase
        end
      endcase
    end else if (newer) begin
      dir = (abs_gap(q_a, q_b) < abs_gap(q_b, q_c)) ? DIR_ABOVE : DIR_LEFT;
    end else begin
      dir = (abs_gap(q_a, q_b) <= abs_gap(q_b, q_c)) ? DIR_ABOVE : DIR_LEFT;
    end
    res.direction  = dir;
    res.prediction = (dir == DIR_ABOVE) ? q_c[DC_W-1:0] : q_a[DC_W-1:0];
    return res;
  endfunction

  task automatic note_fail(string what, idc_res_t want, idc_res_t got, logic has_want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      if (has_want)
        $display("[%0t] %s: expected prediction=%0d direction=%0d, %s=%0d direction=%0d",
                 $time, what, want.prediction, want.direction, "got prediction",
                 got.prediction, got.direction);
      else
        $display("[%0t] %s: got prediction=%0d direction=%0d",
                 $time, what, got.prediction, got.direction);
    end
  endtask

  always @(posedge clk) begin
    idc_item_t blk;
    idc_res_t  want;
    idc_res_t  got;
    if (!rst_n) begin
      codec_ver = CODEC_RESET;
      expected_dc_q.delete();
    end else begin
      if (cfg_wr_en)
        codec_ver = cfg_wr_data;
      if (in_tvalid && in_tready) begin
        blk.block_num      = in_tdata[2:0];
        blk.dc_left        = in_tdata[15:3];
        blk.dc_above_left  = in_tdata[28:16];
        blk.dc_above       = in_tdata[41:29];
        blk.dc_scale       = in_tdata[48:42];
        blk.first_row      = in_tdata[49];
        blk.inter_intra    = in_tdata[50];
        blk.aic_dir        = in_tdata[52:51];
        blk.left_pixel_sum = in_tdata[66:53];
        blk.top_pixel_sum  = in_tdata[80:67];
        blk.at_left_edge   = in_tdata[81];
        blk.at_top_edge    = in_tdata[82];
        expected_dc_q.push_back(predict_dc(blk, codec_ver));
      end
      if (out_tvalid && out_tready) begin
        got.prediction = out_tdata[12:0];
        got.direction  = out_tdata[13];
        if (expected_dc_q.size() == 0) begin
          note_fail("unexpected result", got, got, 1'b0);
        end else begin
          want = expected_dc_q.pop_front();
          if (got.prediction !== want.prediction)
            note_fail("prediction mismatch", want, got, 1'b1);
          if (got.direction !== want.direction)
            note_fail("direction mismatch", want, got, 1'b1);
        end
      end
    end
    pending_count = expected_dc_q.size();
  end

endmodule

// ----- sim/tb_intra_dc_gradient_predictor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_intra_dc_gradient_predictor
// Stimulus and verdict for the intra DC gradient predictor.
// ----------------------------------------------------------------------------
// Drives a short directed set of blocks, then random blocks over every codec
// version, with random gaps on both sides, a stretch without gaps and one
// long output hold-off. Checking is done by idc_prediction_checker.
module tb_intra_dc_gradient_predictor;
  import idc_pkg::*;

  localparam int PHASE_ITEMS  = 128;
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_LIMIT   = 3000;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [VER_W-1:0] CODEC_V1   = 3'd0;
  localparam logic [VER_W-1:0] CODEC_V2   = 3'd1;
  localparam logic [VER_W-1:0] CODEC_WMV2 = 3'd4;
  localparam logic [VER_W-1:0] CODEC_X5   = 3'd5;
  localparam logic [VER_W-1:0] CODEC_X6   = 3'd6;
  localparam logic [VER_W-1:0] CODEC_X7   = 3'd7;
  localparam logic [VER_W-1:0] VERSION_PLAN [8] = '{
    CODEC_WMV2, CODEC_V1, CODEC_V2, CODEC_WMV1, CODEC_X7, CODEC_X5, CODEC_X6, CODEC_V3
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [VER_W-1:0]      cfg_wr_data = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  hold_req = 1'b0;
  logic                  hold_done = 1'b0;
  logic                  calm = 1'b0;
  int                    mismatch_count;
  int                    pending_count;
  int                    idle_cycles = 0;

  always #5 clk = ~clk;

  intra_dc_gradient_predictor i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  idc_prediction_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  // result side: random stalls, one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        out_tready <= calm || ($urandom_range(99) >= 10);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  function automatic idc_item_t dc_item(int n, int a, int b, int c, int sc);
    idc_item_t it;
    it               = '0;
    it.block_num     = BLK_W'(n);
    it.dc_left       = DC_W'(a);
    it.dc_above_left = DC_W'(b);
    it.dc_above      = DC_W'(c);
    it.dc_scale      = SCALE_W'(sc);
    return it;
  endfunction

  function automatic int unsigned near_dc(int unsigned base, int unsigned spread);
    int v;
    v = int'(base) + int'($urandom_range(2 * spread)) - int'(spread);
    return (v < 0) ? 0 : (v > 8191) ? 8191 : v;
  endfunction

  function automatic idc_item_t random_block();
    idc_item_t   it;
    int unsigned pick;
    int unsigned base;
    int unsigned spread;
    it           = '0;
    it.block_num = BLK_W'(($urandom_range(99) < 10) ? $urandom_range(7, 6)
                                                    : $urandom_range(5));
    pick = $urandom_range(99);
    if (pick < 4)       it.dc_scale = SCALE_W'(0);
    else if (pick < 8)  it.dc_scale = SCALE_W'(127);
    else if (pick < 14) it.dc_scale = SCALE_W'(1);
    else if (pick < 60) it.dc_scale = SCALE_W'($urandom_range(31, 2));
    else                it.dc_scale = SCALE_W'($urandom_range(127));
    pick = $urandom_range(99);
    if (pick < 35) begin
      it.dc_left       = DC_W'($urandom_range(8191));
      it.dc_above_left = DC_W'($urandom_range(8191));
      it.dc_above      = DC_W'($urandom_range(8191));
    end else if (pick < 75) begin
      // clustered neighbors make gradient ties after rounding
      base             = $urandom_range(8191);
      spread           = 2 * 32'(it.dc_scale) + 2;
      it.dc_left       = DC_W'(base);
      it.dc_above_left = DC_W'(near_dc(base, spread));
      it.dc_above      = DC_W'(near_dc(base, spread));
    end else if (pick < 85) begin
      it.dc_left       = DC_W'($urandom_range(8191));
      it.dc_above_left = it.dc_left;
      it.dc_above      = it.dc_left;
    end else begin
      it.dc_left       = DC_W'($urandom_range(1) ? 8191 : 0);
      it.dc_above_left = DC_W'($urandom_range(1) ? 8191 : 0);
      it.dc_above      = DC_W'($urandom_range(1) ? 8191 : 0);
    end
    it.first_row      = ($urandom_range(99) < 30);
    it.inter_intra    = ($urandom_range(99) < 40);
    it.aic_dir        = AIC_W'($urandom_range(3));
    it.left_pixel_sum = SUM_W'(($urandom_range(99) < 10) ? ($urandom_range(1) ? 16383 : 0)
                                                         : $urandom_range(16383));
    it.top_pixel_sum  = SUM_W'(($urandom_range(99) < 10) ? ($urandom_range(1) ? 16383 : 0)
                                                         : $urandom_range(16383));
    it.at_left_edge   = ($urandom_range(99) < 25);
    it.at_top_edge    = ($urandom_range(99) < 25);
    return it;
  endfunction

  // enter and leave at a falling edge; valid stays high into the next item
  task automatic send_block(idc_item_t it);
    if (!calm && $urandom_range(99) < 5) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'd0, it.at_top_edge, it.at_left_edge, it.top_pixel_sum,
                  it.left_pixel_sum, it.aic_dir, it.inter_intra, it.first_row,
                  it.dc_scale, it.dc_above, it.dc_above_left, it.dc_left, it.block_num};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic write_codec(logic [VER_W-1:0] ver);
    in_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= ver;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic send_random(int count, int hold_at);
    for (int i = 0; i < count; i++) begin
      if (i == hold_at)
        hold_req <= 1'b1;
      send_block(random_block());
    end
  endtask

  initial begin
    idc_item_t it;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset version: non-strict test, first-row replacement
    it = dc_item(0, 0, 0, 0, 0);
    send_block(it);
    it = dc_item(7, 8191, 8191, 8191, 127);
    it.first_row = 1'b1; it.inter_intra = 1'b1; it.aic_dir = AIC_ABOVE;
    it.left_pixel_sum = SUM_W'(16383); it.top_pixel_sum = SUM_W'(16383);
    it.at_left_edge = 1'b1; it.at_top_edge = 1'b1;
    send_block(it);
    send_block(dc_item(1, 8191, 0, 8191, 1));
    send_block(dc_item(2, 0, 8191, 0, 1));
    send_block(dc_item(3, 10, 20, 30, 1));
    send_block(dc_item(4, 3, 5, 7, 2));
    it = dc_item(0, 500, 3000, 7000, 8); it.first_row = 1'b1;
    send_block(it);
    it = dc_item(2, 500, 3000, 7000, 8); it.first_row = 1'b1;
    send_block(it);
    it = dc_item(6, 1024, 900, 4000, 16); it.first_row = 1'b1;
    send_block(it);
    it = dc_item(5, 8191, 0, 0, 0); it.first_row = 1'b1;
    send_block(it);
    send_random(PHASE_ITEMS, -1);

    foreach (VERSION_PLAN[p]) begin
      write_codec(VERSION_PLAN[p]);
      if (VERSION_PLAN[p] == CODEC_WMV2) begin
        // inter-intra: fixed blocks, pixel-sum blocks with each direction code
        it = dc_item(0, 100, 200, 300, 1); it.inter_intra = 1'b1;
        it.aic_dir = AIC_Y0_ABOVE;
        it.left_pixel_sum = SUM_W'(16383); it.top_pixel_sum = SUM_W'(8000);
        send_block(it);
        it = dc_item(0, 100, 200, 300, 0); it.inter_intra = 1'b1;
        it.aic_dir = AIC_Y0_LEFT; it.at_left_edge = 1'b1; it.at_top_edge = 1'b1;
        send_block(it);
        for (int n = 4; n < 8; n++) begin
          it = dc_item(n, 100, 200, 300, 3 + n); it.inter_intra = 1'b1;
          it.aic_dir = n[1:0];
          it.left_pixel_sum = SUM_W'(1234 * n); it.top_pixel_sum = SUM_W'(2000 * n);
          it.at_top_edge = (n == 5);
          send_block(it);
        end
        it = dc_item(1, 640, 9, 4000, 5); it.inter_intra = 1'b1;
        send_block(it);
        it = dc_item(2, 640, 9, 4000, 5); it.inter_intra = 1'b1;
        send_block(it);
        it = dc_item(3, 10, 20, 30, 1); it.inter_intra = 1'b1;
        send_block(it);
        send_block(dc_item(3, 10, 20, 30, 1));
        it = dc_item(0, 500, 3000, 7000, 8); it.first_row = 1'b1;
        send_block(it);
      end
      // one phase without gaps on either side
      if (p == 2)
        calm <= 1'b1;
      send_random(PHASE_ITEMS, (p == 1) ? 40 : -1);
      calm <= 1'b0;
    end

    in_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && pending_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/idc_pkg.sv
rtl/core/idc_prep.sv
rtl/core/idc_div.sv
rtl/core/idc_sel.sv
rtl/core/intra_dc_gradient_predictor.sv
rtl/core/idc_checker.sv
sim/idc_prediction_checker.sv
sim/tb_intra_dc_gradient_predictor.sv
